FILE: rtl/vmpc_mac_engine_assert.svh
// assertion macros for the vmpc mac engine
`ifndef VMPC_MAC_ENGINE_ASSERT_SVH
`define VMPC_MAC_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define VMPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("vmpc assertion failed");
`define VMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("vmpc assertion failed");
`else
`define VMPC_ASSERT(lbl, clk, rst_n, prop)
`define VMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/vmpc_pkg.sv
package vmpc_pkg;

	localparam int KEY_MAX_DEF = 64;
	localparam int IV_MAX_DEF  = 64;
	localparam int PERM_DEPTH  = 256;
	localparam int TAG_LEN     = 32;
	localparam int ROUNDS      = 768;
	localparam int POST_LAST   = 24;
	localparam int MAC_LEN     = 20;
	localparam int CHAIN_LEN   = 4;
	localparam int LEN_W       = 7;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;

	localparam logic [2:0] KIND_KEY    = 3'd0;
	localparam logic [2:0] KIND_IV     = 3'd1;
	localparam logic [2:0] KIND_START  = 3'd2;
	localparam logic [2:0] KIND_MSG    = 3'd3;
	localparam logic [2:0] KIND_FINISH = 3'd4;

	localparam logic REG_KEY_LEN = 1'b0;
	localparam logic REG_IV_LEN  = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0] key_len;
		logic [LEN_W-1:0] iv_len;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] mac_byte;
		logic       last;
	} result_t;

endpackage

FILE: rtl/vmpc_mac_engine.sv
// vmpc mac engine
// request channel: req_valid/req_stall with kind, position, data_byte.
// kinds: write key byte, write iv byte, start, message byte, finish.
// result channel: mac_valid/mac_stall with mac_byte and last (set on byte 20).
// config: apb port, key_length at 0x0 and iv_length at 0x4, pready always high.
// all permutation updates go through one 256x8 memory (one read, one
// write per cycle, registered read data), so every step is a chain of reads.
// key and iv writes go straight into their stores. start fills all 256
// permutation entries, then runs 768 schedule rounds over the key and 768 over the iv.
// a message byte runs the absorb, chain update, tag fold and swap steps.
// a finish runs 24 post rounds, 768 tag schedule rounds and 20 output rounds,
// then the full start again.
// req_stall stays high while any of this runs; requests before the first start
// that are message bytes or finishes are dropped.
// a mac byte sits in an output register; a stalled receiver holds it and the
// engine waits before producing the next one.
// reset clears the control state and sets both lengths to 16; the engine is
// then unarmed until a start.
module vmpc_mac_engine #(
	parameter int KEY_MAX = vmpc_pkg::KEY_MAX_DEF,
	parameter int IV_MAX  = vmpc_pkg::IV_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  kind,
	input  logic [5:0]  position,
	input  logic [7:0]  data_byte,
	output logic        mac_valid,
	input  logic        mac_stall,
	output logic [7:0]  mac_byte,
	output logic        last
);

	vmpc_pkg::cfg_t    cfg_q;
	vmpc_pkg::result_t res;
	logic              mac_valid_q;
	logic [7:0]        mac_byte_q;
	logic              last_q;
	logic              res_take;
	logic              wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == vmpc_pkg::REG_IV_LEN) ? 32'(cfg_q.iv_len) : 32'(cfg_q.key_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_len <= vmpc_pkg::LEN_RESET;
			cfg_q.iv_len  <= vmpc_pkg::LEN_RESET;
		end else if (wr) begin
			if (paddr[2] == vmpc_pkg::REG_KEY_LEN) begin
				cfg_q.key_len <= pwdata[6:0];
			end else begin
				cfg_q.iv_len <= pwdata[6:0];
			end
		end
	end

	assign res_take = !mac_valid_q || !mac_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_valid_q <= 1'b0;
		end else if (res.valid) begin
			mac_valid_q <= 1'b1;
		end else if (!mac_stall) begin
			mac_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mac_byte_q <= res.mac_byte;
			last_q     <= res.last;
		end
	end

	assign mac_valid = mac_valid_q;
	assign mac_byte  = mac_byte_q;
	assign last      = last_q;

	vmpc_core #(.KEY_MAX(KEY_MAX), .IV_MAX(IV_MAX)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.position  (position),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.res_take  (res_take),
		.res       (res)
	);

endmodule

FILE: rtl/vmpc_ram.sv
module vmpc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             ren,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/vmpc_core.sv
`include "vmpc_mac_engine_assert.svh"

module vmpc_core #(
	parameter int KEY_MAX = vmpc_pkg::KEY_MAX_DEF,
	parameter int IV_MAX  = vmpc_pkg::IV_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         kind,
	input  logic [5:0]         position,
	input  logic [7:0]         data_byte,
	input  vmpc_pkg::cfg_t     cfg,
	input  logic               res_take,
	output vmpc_pkg::result_t  res
);

	localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int IAW = (IV_MAX > 1) ? $clog2(IV_MAX) : 1;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_FILL = 5'd1;
	localparam logic [4:0] ST_K1   = 5'd2;
	localparam logic [4:0] ST_K2   = 5'd3;
	localparam logic [4:0] ST_K3   = 5'd4;
	localparam logic [4:0] ST_K4   = 5'd5;
	localparam logic [4:0] ST_K5   = 5'd6;
	localparam logic [4:0] ST_A0   = 5'd7;
	localparam logic [4:0] ST_A1   = 5'd8;
	localparam logic [4:0] ST_A2   = 5'd9;
	localparam logic [4:0] ST_A3   = 5'd10;
	localparam logic [4:0] ST_A4   = 5'd11;
	localparam logic [4:0] ST_A5   = 5'd12;
	localparam logic [4:0] ST_C3   = 5'd13;
	localparam logic [4:0] ST_C2   = 5'd14;
	localparam logic [4:0] ST_C1   = 5'd15;
	localparam logic [4:0] ST_C0   = 5'd16;
	localparam logic [4:0] ST_FT   = 5'd17;
	localparam logic [4:0] ST_W0   = 5'd18;
	localparam logic [4:0] ST_W1   = 5'd19;
	localparam logic [4:0] ST_W2   = 5'd20;
	localparam logic [4:0] ST_W3   = 5'd21;
	localparam logic [4:0] ST_O0   = 5'd22;
	localparam logic [4:0] ST_O1   = 5'd23;
	localparam logic [4:0] ST_O2   = 5'd24;
	localparam logic [4:0] ST_O3   = 5'd25;
	localparam logic [4:0] ST_O4   = 5'd26;
	localparam logic [4:0] ST_O5   = 5'd27;
	localparam logic [4:0] ST_O6   = 5'd28;
	localparam logic [4:0] ST_O7   = 5'd29;

	localparam logic [1:0] SRC_KEY = 2'd0;
	localparam logic [1:0] SRC_IV  = 2'd1;
	localparam logic [1:0] SRC_TAG = 2'd2;

	localparam int LW = vmpc_pkg::LEN_W;

	function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v, input int max);
		logic [LW-1:0] r;
		if (v == '0) begin
			r = LW'(1);
		end else if (int'(v) > max) begin
			r = LW'(max);
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [4:0]    state_q;
	logic [1:0]    src_q;
	logic          fin_q;
	logic          ready_q;
	logic [7:0]    s_q;
	logic [7:0]    n_q;
	logic [4:0]    g_q;
	logic [7:0]    ch_q [vmpc_pkg::CHAIN_LEN];
	logic [9:0]    c_q;
	logic [LW-1:0] srci_q;
	logic [LW-1:0] klen_q;
	logic [LW-1:0] ilen_q;
	logic [4:0]    r_q;
	logic [2:0]    j_q;
	logic [7:0]    pi_q;
	logic [7:0]    ps_q;
	logic [7:0]    m_q;
	logic [7:0]    cx_q;
	logic [vmpc_pkg::TAG_LEN-1:0] tag_v_q;
	logic          tag_rv_q;

	logic          p_we;
	logic [7:0]    p_waddr;
	logic [7:0]    p_wdata;
	logic          p_ren;
	logic [7:0]    p_raddr;
	logic [7:0]    p_rd;

	logic          t_we;
	logic [4:0]    t_waddr;
	logic [7:0]    t_wdata;
	logic [4:0]    t_raddr;
	logic [7:0]    t_rd;

	logic          k_we;
	logic          i_we;
	logic [7:0]    k_rd;
	logic [7:0]    i_rd;

	logic          accept;
	logic          start_go;
	logic [7:0]    k_add;
	logic [7:0]    src_b;
	logic [LW-1:0] cur_len;
	logic [LW-1:0] srci_inc;
	logic [1:0]    jm1;
	logic [7:0]    tag_old;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign start_go  = (accept && kind == vmpc_pkg::KIND_START) ||
		(state_q == ST_O7 && r_q == 5'(vmpc_pkg::MAC_LEN - 1));
	assign k_add     = fin_q ? 8'(r_q) : 8'd0;
	assign jm1       = 2'(j_q - 3'd1);
	assign tag_old   = tag_rv_q ? t_rd : 8'd0;
	assign srci_inc  = srci_q + LW'(1);

	assign k_we = accept && kind == vmpc_pkg::KIND_KEY && int'(position) < KEY_MAX;
	assign i_we = accept && kind == vmpc_pkg::KIND_IV && int'(position) < IV_MAX;

	always_comb begin
		case (src_q)
			SRC_KEY: begin
				src_b   = k_rd;
				cur_len = klen_q;
			end
			SRC_IV: begin
				src_b   = i_rd;
				cur_len = ilen_q;
			end
			default: begin
				src_b   = tag_old;
				cur_len = LW'(vmpc_pkg::TAG_LEN);
			end
		endcase
	end

	// permutation port control
	always_comb begin
		p_we    = 1'b0;
		p_waddr = 8'd0;
		p_wdata = 8'd0;
		p_ren   = (state_q != ST_O5);
		p_raddr = 8'd0;
		unique case (state_q)
			ST_FILL: begin
				p_we    = 1'b1;
				p_waddr = c_q[7:0];
				p_wdata = c_q[7:0];
			end
			ST_K1: p_raddr = c_q[7:0];
			ST_K2: p_raddr = s_q + p_rd + src_b;
			ST_K3: p_raddr = p_rd;
			ST_K4: begin
				p_we    = 1'b1;
				p_waddr = c_q[7:0];
				p_wdata = p_rd;
			end
			ST_K5: begin
				p_we    = 1'b1;
				p_waddr = s_q;
				p_wdata = pi_q;
			end
			ST_A0: p_raddr = n_q;
			ST_A1: p_raddr = s_q + p_rd;
			ST_A2: p_raddr = fin_q ? (ch_q[3] + ch_q[2] + k_add) : p_rd;
			ST_A3: p_raddr = p_rd;
			ST_A4: p_raddr = p_rd + 8'd1;
			ST_A5: p_raddr = ch_q[3] + ch_q[2] + k_add;
			ST_C3: p_raddr = ch_q[2] + ch_q[1] + k_add;
			ST_C2: p_raddr = ch_q[1] + ch_q[0] + k_add;
			ST_C1: p_raddr = ch_q[0] + s_q + (fin_q ? k_add : cx_q);
			ST_W0: p_raddr = n_q;
			ST_W1: p_raddr = s_q;
			ST_W2: begin
				p_we    = 1'b1;
				p_waddr = n_q;
				p_wdata = p_rd;
			end
			ST_W3: begin
				p_we    = 1'b1;
				p_waddr = s_q;
				p_wdata = pi_q;
			end
			ST_O0: p_raddr = 8'(r_q);
			ST_O1: p_raddr = s_q + p_rd;
			ST_O2: p_raddr = p_rd;
			ST_O3: p_raddr = p_rd;
			ST_O4: p_raddr = p_rd + 8'd1;
			ST_O6: begin
				p_we    = 1'b1;
				p_waddr = 8'(r_q);
				p_wdata = ps_q;
			end
			ST_O7: begin
				p_we    = 1'b1;
				p_waddr = s_q;
				p_wdata = pi_q;
			end
			default: ;
		endcase
	end

	assign t_raddr = (state_q == ST_FT) ? (g_q + 5'(j_q)) : 5'(srci_q);
	assign t_we    = (state_q == ST_FT) && (j_q != 3'd0);
	assign t_waddr = g_q + 5'(jm1);
	assign t_wdata = tag_old ^ ch_q[jm1];

	assign res.valid    = (state_q == ST_O5) && res_take;
	assign res.mac_byte = p_rd;
	assign res.last     = (r_q == 5'(vmpc_pkg::MAC_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			src_q    <= SRC_KEY;
			fin_q    <= 1'b0;
			ready_q  <= 1'b0;
			s_q      <= 8'd0;
			n_q      <= 8'd0;
			g_q      <= 5'd0;
			for (int i = 0; i < vmpc_pkg::CHAIN_LEN; i++) begin
				ch_q[i] <= 8'd0;
			end
			c_q      <= 10'd0;
			srci_q   <= '0;
			klen_q   <= vmpc_pkg::LEN_RESET;
			ilen_q   <= vmpc_pkg::LEN_RESET;
			r_q      <= 5'd0;
			j_q      <= 3'd0;
			pi_q     <= 8'd0;
			ps_q     <= 8'd0;
			m_q      <= 8'd0;
			cx_q     <= 8'd0;
			tag_v_q  <= '0;
			tag_rv_q <= 1'b0;
		end else begin
			tag_rv_q <= tag_v_q[t_raddr];
			if (t_we) begin
				tag_v_q[t_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == vmpc_pkg::KIND_MSG && ready_q) begin
						m_q     <= data_byte;
						fin_q   <= 1'b0;
						state_q <= ST_A0;
					end else if (accept && kind == vmpc_pkg::KIND_FINISH && ready_q) begin
						fin_q   <= 1'b1;
						r_q     <= 5'd1;
						state_q <= ST_A0;
					end
				end
				ST_FILL: begin
					if (c_q == 10'(vmpc_pkg::PERM_DEPTH - 1)) begin
						c_q     <= 10'd0;
						srci_q  <= '0;
						src_q   <= SRC_KEY;
						state_q <= ST_K1;
					end else begin
						c_q <= c_q + 10'd1;
					end
				end
				ST_K1: state_q <= ST_K2;
				ST_K2: begin
					pi_q    <= p_rd;
					state_q <= ST_K3;
				end
				ST_K3: begin
					s_q     <= p_rd;
					state_q <= ST_K4;
				end
				ST_K4: state_q <= ST_K5;
				ST_K5: begin
					if (c_q == 10'(vmpc_pkg::ROUNDS - 1)) begin
						c_q    <= 10'd0;
						srci_q <= '0;
						case (src_q)
							SRC_KEY: begin
								src_q   <= SRC_IV;
								state_q <= ST_K1;
							end
							SRC_IV: begin
								n_q     <= 8'd0;
								ready_q <= 1'b1;
								state_q <= ST_IDLE;
							end
							default: begin
								r_q     <= 5'd0;
								state_q <= ST_O0;
							end
						endcase
					end else begin
						srci_q  <= (srci_inc == cur_len) ? '0 : srci_inc;
						c_q     <= c_q + 10'd1;
						state_q <= ST_K1;
					end
				end
				ST_A0: state_q <= ST_A1;
				ST_A1: state_q <= ST_A2;
				ST_A2: begin
					s_q     <= p_rd;
					state_q <= fin_q ? ST_C3 : ST_A3;
				end
				ST_A3: state_q <= ST_A4;
				ST_A4: state_q <= ST_A5;
				ST_A5: begin
					cx_q    <= m_q ^ p_rd;
					state_q <= ST_C3;
				end
				ST_C3: begin
					ch_q[3] <= p_rd;
					state_q <= ST_C2;
				end
				ST_C2: begin
					ch_q[2] <= p_rd;
					state_q <= ST_C1;
				end
				ST_C1: begin
					ch_q[1] <= p_rd;
					state_q <= ST_C0;
				end
				ST_C0: begin
					ch_q[0] <= p_rd;
					j_q     <= 3'd0;
					state_q <= ST_FT;
				end
				ST_FT: begin
					if (j_q == 3'(vmpc_pkg::CHAIN_LEN)) begin
						g_q     <= g_q + 5'(vmpc_pkg::CHAIN_LEN);
						state_q <= ST_W0;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				ST_W0: state_q <= ST_W1;
				ST_W1: begin
					pi_q    <= p_rd;
					state_q <= ST_W2;
				end
				ST_W2: state_q <= ST_W3;
				ST_W3: begin
					n_q <= n_q + 8'd1;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (r_q != 5'(vmpc_pkg::POST_LAST)) begin
						r_q     <= r_q + 5'd1;
						state_q <= ST_A0;
					end else begin
						c_q     <= 10'd0;
						srci_q  <= '0;
						src_q   <= SRC_TAG;
						state_q <= ST_K1;
					end
				end
				ST_O0: state_q <= ST_O1;
				ST_O1: begin
					pi_q    <= p_rd;
					state_q <= ST_O2;
				end
				ST_O2: begin
					s_q     <= p_rd;
					state_q <= ST_O3;
				end
				ST_O3: begin
					ps_q    <= p_rd;
					state_q <= ST_O4;
				end
				ST_O4: state_q <= ST_O5;
				ST_O5: begin
					if (res_take) begin
						state_q <= ST_O6;
					end
				end
				ST_O6: state_q <= ST_O7;
				ST_O7: begin
					r_q <= r_q + 5'd1;
					if (r_q != 5'(vmpc_pkg::MAC_LEN - 1)) begin
						state_q <= ST_O0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (start_go) begin
				s_q     <= 8'd0;
				n_q     <= 8'd0;
				g_q     <= 5'd0;
				for (int i = 0; i < vmpc_pkg::CHAIN_LEN; i++) begin
					ch_q[i] <= 8'd0;
				end
				tag_v_q <= '0;
				c_q     <= 10'd0;
				fin_q   <= 1'b0;
				klen_q  <= clamp_len(cfg.key_len, KEY_MAX);
				ilen_q  <= clamp_len(cfg.iv_len, IV_MAX);
				state_q <= ST_FILL;
			end
		end
	end

	vmpc_ram #(.DEPTH(vmpc_pkg::PERM_DEPTH), .WIDTH(8)) u_perm (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.ren   (p_ren),
		.raddr (p_raddr),
		.rdata (p_rd)
	);

	vmpc_ram #(.DEPTH(vmpc_pkg::TAG_LEN), .WIDTH(8)) u_tag (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.ren   (1'b1),
		.raddr (t_raddr),
		.rdata (t_rd)
	);

	vmpc_ram #(.DEPTH(KEY_MAX), .WIDTH(8), .AW(KAW)) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (KAW'(position)),
		.wdata (data_byte),
		.ren   (1'b1),
		.raddr (KAW'(srci_q)),
		.rdata (k_rd)
	);

	vmpc_ram #(.DEPTH(IV_MAX), .WIDTH(8), .AW(IAW)) u_iv (
		.clk   (clk),
		.we    (i_we),
		.waddr (IAW'(position)),
		.wdata (data_byte),
		.ren   (1'b1),
		.raddr (IAW'(srci_q)),
		.rdata (i_rd)
	);

	`VMPC_ASSERT(a_g_aligned, clk, arst_n, g_q[1:0] == 2'd0)
	`VMPC_ASSERT(a_mac_armed, clk, arst_n, res.valid |-> ready_q)
	`VMPC_ASSERT(a_srci_range, clk, arst_n, (state_q == ST_K1) |-> (srci_q < cur_len))
	`VMPC_ASSERT_NEXT(a_arm_after_iv, clk, arst_n, state_q == ST_K5 && src_q == SRC_IV && c_q == 10'(vmpc_pkg::ROUNDS - 1), ready_q && state_q == ST_IDLE)

endmodule

FILE: dv/vmpc_mac_engine_tb.sv
module vmpc_mac_engine_tb;

	localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
	localparam logic [2:0] ADDR_KEY_LEN   = {vmpc_pkg::REG_KEY_LEN, 2'b00};
	localparam logic [2:0] ADDR_IV_LEN    = {vmpc_pkg::REG_IV_LEN, 2'b00};
	localparam int DRAIN_CYCLES = 13000;

	typedef struct {
		bit [2:0] kind;
		bit [5:0] position;
		bit [7:0] data;
	} request_t;

	typedef struct {
		bit [7:0] mac_byte;
		bit       last;
	} mac_out_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  kind;
	logic [5:0]  position;
	logic [7:0]  data_byte;
	logic        mac_valid;
	logic        mac_stall;
	logic [7:0]  mac_byte;
	logic        last;

	request_t pending_requests[$];
	mac_out_t mac_expect[$];
	int       mismatches = 0;
	int       idle_pct;
	bit       req_taken;

	// engine mirror
	bit [7:0] perm[vmpc_pkg::PERM_DEPTH];
	bit [7:0] tag[vmpc_pkg::TAG_LEN];
	bit [7:0] key_mem[vmpc_pkg::KEY_MAX_DEF];
	bit [7:0] iv_mem[vmpc_pkg::IV_MAX_DEF];
	bit [7:0] s_val;
	bit [7:0] n_val;
	bit [4:0] g_val;
	bit [7:0] chain[vmpc_pkg::CHAIN_LEN];
	bit       armed;
	bit [6:0] key_len_reg;
	bit [6:0] iv_len_reg;

	// stimulus bookkeeping
	bit key_written[vmpc_pkg::KEY_MAX_DEF];
	bit iv_written[vmpc_pkg::IV_MAX_DEF];

	vmpc_mac_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .position(position), .data_byte(data_byte),
		.mac_valid(mac_valid), .mac_stall(mac_stall),
		.mac_byte(mac_byte), .last(last)
	);

	always #4 clk = ~clk;

	function automatic int clamp_len(bit [6:0] v, int max_len);
		if (v == 0)
			return 1;
		if (int'(v) > max_len)
			return max_len;
		return int'(v);
	endfunction

	function automatic void perm_swap(bit [7:0] a, bit [7:0] b);
		bit [7:0] t;
		t = perm[a];
		perm[a] = perm[b];
		perm[b] = t;
	endfunction

	// src 0 key, 1 iv, 2 tag
	function automatic void schedule_rounds(int src, int len);
		bit [7:0] idx;
		bit [7:0] ix;
		bit [7:0] b;
		for (int c = 0; c < vmpc_pkg::ROUNDS; c++) begin
			idx = c[7:0];
			if (src == 0)
				b = key_mem[c % len];
			else if (src == 1)
				b = iv_mem[c % len];
			else
				b = tag[c % vmpc_pkg::TAG_LEN];
			ix = s_val + perm[idx] + b;
			s_val = perm[ix];
			perm_swap(idx, s_val);
		end
	endfunction

	function automatic void session_start();
		s_val = 0;
		n_val = 0;
		g_val = 0;
		for (int i = 0; i < vmpc_pkg::CHAIN_LEN; i++)
			chain[i] = 0;
		for (int i = 0; i < vmpc_pkg::TAG_LEN; i++)
			tag[i] = 0;
		for (int i = 0; i < vmpc_pkg::PERM_DEPTH; i++)
			perm[i] = i[7:0];
		schedule_rounds(0, clamp_len(key_len_reg, vmpc_pkg::KEY_MAX_DEF));
		schedule_rounds(1, clamp_len(iv_len_reg, vmpc_pkg::IV_MAX_DEF));
		n_val = 0;
		armed = 1;
	endfunction

	function automatic void tag_fold();
		tag[g_val] ^= chain[0];
		tag[g_val + 5'd1] ^= chain[1];
		tag[g_val + 5'd2] ^= chain[2];
		tag[g_val + 5'd3] ^= chain[3];
		g_val = g_val + 5'd4;
		perm_swap(n_val, s_val);
		n_val = n_val + 8'd1;
	endfunction

	function automatic void msg_absorb(bit [7:0] m);
		bit [7:0] ix;
		bit [7:0] c;
		ix = s_val + perm[n_val];
		s_val = perm[ix];
		ix = perm[perm[s_val]] + 8'd1;
		c = m ^ perm[ix];
		ix = chain[3] + chain[2];
		chain[3] = perm[ix];
		ix = chain[2] + chain[1];
		chain[2] = perm[ix];
		ix = chain[1] + chain[0];
		chain[1] = perm[ix];
		ix = chain[0] + s_val + c;
		chain[0] = perm[ix];
		tag_fold();
	endfunction

	function automatic void mac_finish();
		bit [7:0] ix;
		bit [7:0] rb;
		mac_out_t o;
		for (int r = 1; r <= vmpc_pkg::POST_LAST; r++) begin
			rb = r[7:0];
			ix = s_val + perm[n_val];
			s_val = perm[ix];
			ix = chain[3] + chain[2] + rb;
			chain[3] = perm[ix];
			ix = chain[2] + chain[1] + rb;
			chain[2] = perm[ix];
			ix = chain[1] + chain[0] + rb;
			chain[1] = perm[ix];
			ix = chain[0] + s_val + rb;
			chain[0] = perm[ix];
			tag_fold();
		end
		schedule_rounds(2, vmpc_pkg::TAG_LEN);
		for (int r = 0; r < vmpc_pkg::MAC_LEN; r++) begin
			rb = r[7:0];
			ix = s_val + perm[rb];
			s_val = perm[ix];
			ix = perm[perm[s_val]] + 8'd1;
			o.mac_byte = perm[ix];
			o.last = (r == vmpc_pkg::MAC_LEN - 1);
			mac_expect.push_back(o);
			perm_swap(rb, s_val);
		end
		session_start();
	endfunction

	function automatic void mac_predict(request_t q);
		case (q.kind)
			vmpc_pkg::KIND_KEY: key_mem[q.position] = q.data;
			vmpc_pkg::KIND_IV: iv_mem[q.position] = q.data;
			vmpc_pkg::KIND_START: session_start();
			vmpc_pkg::KIND_MSG: if (armed) msg_absorb(q.data);
			vmpc_pkg::KIND_FINISH: if (armed) mac_finish();
			default: ;
		endcase
	endfunction

	function automatic void push_request(bit [2:0] k, bit [5:0] p, bit [7:0] d);
		request_t q;
		q.kind = k;
		q.position = p;
		q.data = d;
		if (k == vmpc_pkg::KIND_KEY)
			key_written[p] = 1;
		if (k == vmpc_pkg::KIND_IV)
			iv_written[p] = 1;
		pending_requests.push_back(q);
	endfunction

	task automatic cfg_write(logic [2:0] addr, bit [6:0] value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= {25'd0, value};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == ADDR_KEY_LEN)
			key_len_reg = value;
		else
			iv_len_reg = value;
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || req_valid || mac_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(bit [6:0] klen, bit [6:0] ilen, int n_rand);
		int kl;
		int il;
		int r;
		cfg_write(ADDR_KEY_LEN, klen);
		cfg_write(ADDR_IV_LEN, ilen);
		kl = clamp_len(klen, vmpc_pkg::KEY_MAX_DEF);
		il = clamp_len(ilen, vmpc_pkg::IV_MAX_DEF);
		for (int i = 0; i < kl; i++)
			if (!key_written[i])
				push_request(vmpc_pkg::KIND_KEY, i[5:0], 8'($urandom_range(0, 255)));
		for (int i = 0; i < il; i++)
			if (!iv_written[i])
				push_request(vmpc_pkg::KIND_IV, i[5:0], 8'($urandom_range(0, 255)));
		push_request(vmpc_pkg::KIND_START, 6'($urandom_range(0, 63)),
			8'($urandom_range(0, 255)));
		for (int i = 0; i < n_rand; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				push_request(vmpc_pkg::KIND_MSG, 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
			else if (r < 86)
				push_request(vmpc_pkg::KIND_KEY, 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
			else if (r < 92)
				push_request(vmpc_pkg::KIND_IV, 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
			else if (r < 95)
				push_request(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
					6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
			else if (r < 98)
				push_request(vmpc_pkg::KIND_FINISH, 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
			else
				push_request(vmpc_pkg::KIND_START, 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
		end
		push_request(vmpc_pkg::KIND_FINISH, 6'($urandom_range(0, 63)),
			8'($urandom_range(0, 255)));
		drain();
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_requests.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
					req_valid <= 0;
				end else begin
					req_valid <= 1;
					kind <= pending_requests[0].kind;
					position <= pending_requests[0].position;
					data_byte <= pending_requests[0].data;
					void'(pending_requests.pop_front());
				end
			end
			mac_stall <= ($urandom_range(0, 99) < idle_pct);
		end else begin
			req_valid <= 0;
			kind <= '0;
			position <= '0;
			data_byte <= '0;
			mac_stall <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		request_t q;
		mac_out_t e;
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken) begin
			q.kind = kind;
			q.position = position;
			q.data = data_byte;
			mac_predict(q);
		end
		if (arst_n && mac_valid && !mac_stall) begin
			if (mac_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected mac byte %02h last %0b", mac_byte, last);
			end else begin
				e = mac_expect.pop_front();
				if (mac_byte !== e.mac_byte || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mac mismatch: expected %02h/%0b got %02h/%0b",
							e.mac_byte, e.last, mac_byte, last);
				end
			end
		end
	end

	initial begin
		#(8 * 30000000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 9;
		key_len_reg = vmpc_pkg::LEN_RESET;
		iv_len_reg = vmpc_pkg::LEN_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: unarmed drops, spare kinds, store extremes, shortest lengths
		cfg_write(ADDR_KEY_LEN, 7'd1);
		cfg_write(ADDR_IV_LEN, 7'd1);
		push_request(vmpc_pkg::KIND_MSG, 6'd0, 8'hff);
		push_request(vmpc_pkg::KIND_FINISH, 6'd63, 8'h00);
		push_request(KIND_SPARE_LO, 6'd63, 8'hff);
		push_request(KIND_SPARE_MID, 6'd0, 8'h00);
		push_request(KIND_SPARE_HI, 6'd21, 8'h5a);
		push_request(vmpc_pkg::KIND_KEY, 6'd63, 8'hff);
		push_request(vmpc_pkg::KIND_IV, 6'd63, 8'h00);
		push_request(vmpc_pkg::KIND_KEY, 6'd0, 8'h00);
		push_request(vmpc_pkg::KIND_IV, 6'd0, 8'hff);
		push_request(vmpc_pkg::KIND_START, 6'd0, 8'h00);
		push_request(vmpc_pkg::KIND_MSG, 6'd63, 8'h00);
		push_request(vmpc_pkg::KIND_MSG, 6'd0, 8'hff);
		push_request(vmpc_pkg::KIND_MSG, 6'd42, 8'h5a);
		push_request(vmpc_pkg::KIND_FINISH, 6'd0, 8'h00);
		push_request(vmpc_pkg::KIND_MSG, 6'd0, 8'ha5);
		push_request(vmpc_pkg::KIND_START, 6'd63, 8'hff);
		push_request(vmpc_pkg::KIND_FINISH, 6'd0, 8'hff);
		drain();

		run_phase(7'd64, 7'd64, 40);
		idle_pct = 0;
		run_phase(7'd0, 7'd127, 50);
		idle_pct = 9;
		run_phase(7'd127, 7'd0, 50);
		run_phase(vmpc_pkg::LEN_RESET, vmpc_pkg::LEN_RESET, 50);
		run_phase(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), 50);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
